### rtl/core/kltc_pkg.sv
// shared types and constants for the keyed table with oldest-store eviction
// holds the operation codes, controller states, scan record and write command
// no dependencies
package kltc_pkg;

	localparam int ADDR_W = 48;
	localparam int KEY_W  = 64;
	localparam int TYPE_W = 8;
	localparam int SEQ_W  = 32;
	localparam int SLOT_W = 4;
	// wide enough for any slot index up to the largest table
	localparam int IDX_W  = 8;

	typedef enum logic [2:0] {
		FN_LOOKUP  = 3'd0,
		FN_PUT     = 3'd1,
		FN_DELETE  = 3'd2,
		FN_CLEAR   = 3'd3,
		FN_RESTART = 3'd4,
		FN_NEXT    = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// operation under way, held steady for the whole scan
	typedef struct packed {
		logic [2:0]        func;
		logic [ADDR_W-1:0] addr;
		logic [IDX_W:0]    cursor;
	} scan_req_t;

	// running result handed from cell to cell
	typedef struct packed {
		logic              vld;
		logic              match_hit;
		logic [IDX_W-1:0]  match_idx;
		logic              free_hit;
		logic [IDX_W-1:0]  free_idx;
		logic [SEQ_W-1:0]  min_seq;
		logic [IDX_W-1:0]  min_idx;
		logic [SEQ_W-1:0]  max_seq;
		logic              hit;
		logic [IDX_W-1:0]  hit_idx;
		logic [ADDR_W-1:0] hit_addr;
		logic [KEY_W-1:0]  hit_key_hi;
		logic [KEY_W-1:0]  hit_key_lo;
		logic [TYPE_W-1:0] hit_key_type;
	} scan_rec_t;

	// broadcast update seen by all cells in the commit cycle; put and delete apply only in the addressed slot
	typedef struct packed {
		logic              put;
		logic              del;
		logic              clr;
		logic [IDX_W-1:0]  idx;
		logic [SEQ_W-1:0]  seq;
		logic [ADDR_W-1:0] addr;
		logic [KEY_W-1:0]  key_hi;
		logic [KEY_W-1:0]  key_lo;
		logic [TYPE_W-1:0] key_type;
	} wr_cmd_t;

endpackage

### rtl/core/kltc_cell.sv
// one table slot: stored entry plus one stage of the scan chain
// depends on kltc_pkg
module kltc_cell #(
	parameter int IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  kltc_pkg::scan_req_t req,
	input  kltc_pkg::scan_rec_t rec_in,
	output kltc_pkg::scan_rec_t rec_out,
	input  kltc_pkg::wr_cmd_t   wr
);
	import kltc_pkg::*;

	logic              valid_q;
	logic [ADDR_W-1:0] addr_q;
	logic [KEY_W-1:0]  key_hi_q;
	logic [KEY_W-1:0]  key_lo_q;
	logic [TYPE_W-1:0] key_type_q;
	logic [SEQ_W-1:0]  seq_q;
	scan_rec_t         nxt;
	scan_rec_t         rec_q;
	logic              addr_eq;
	logic              cap;
	logic              wr_here;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	assign addr_eq = valid_q && (addr_q == req.addr);
	assign wr_here = (wr.idx == MY_IDX);

	// fold this slot into the running record
	always_comb begin
		nxt = rec_in;
		cap = 1'b0;
		if (addr_eq && !rec_in.match_hit) begin
			nxt.match_hit = 1'b1;
			nxt.match_idx = MY_IDX;
		end
		if (!valid_q && !rec_in.free_hit) begin
			nxt.free_hit = 1'b1;
			nxt.free_idx = MY_IDX;
		end
		if (valid_q && (IDX == 0 || seq_q < rec_in.min_seq)) begin
			nxt.min_seq = seq_q;
			nxt.min_idx = MY_IDX;
		end
		if (valid_q && seq_q >= rec_in.max_seq) begin
			nxt.max_seq = seq_q;
		end
		if (!rec_in.hit) begin
			if (req.func == FN_LOOKUP)
				cap = addr_eq;
			else if (req.func == FN_NEXT)
				cap = valid_q && ((IDX_W+1)'(IDX) >= req.cursor);
		end
		if (cap) begin
			nxt.hit          = 1'b1;
			nxt.hit_idx      = MY_IDX;
			nxt.hit_addr     = addr_q;
			nxt.hit_key_hi   = key_hi_q;
			nxt.hit_key_lo   = key_lo_q;
			nxt.hit_key_type = key_type_q;
		end
	end

	// record stage toward the next cell, contents held between scans
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (rec_in.vld) begin
			rec_q <= nxt;
		end else begin
			rec_q.vld <= 1'b0;
		end
	end

	assign rec_out = rec_q;

	// slot valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr.clr) begin
			valid_q <= 1'b0;
		end else if (wr.put && wr_here) begin
			valid_q <= 1'b1;
		end else if (wr.del && wr_here) begin
			valid_q <= 1'b0;
		end
	end

	// slot payload
	always_ff @(posedge clk) begin
		if (wr.put && wr_here) begin
			addr_q     <= wr.addr;
			key_hi_q   <= wr.key_hi;
			key_lo_q   <= wr.key_lo;
			key_type_q <= wr.key_type;
			seq_q      <= wr.seq;
		end
	end

endmodule

### rtl/core/keyed_table_with_oldest_store_eviction.sv
// top level: keyed slot table built as a chain of slot cells with a commit controller
// depends on kltc_pkg and kltc_cell
//
// channel  dir  beat contents
// s_*      in   tuser: func[2:0]; tdata: peer_addr, key_hi, key_lo, key_type
// m_*      out  tuser: res_found; tdata: res_addr, res_key_hi, res_key_lo,
//                                        res_key_type, res_slot
//
// the result is loaded after the request beat is latched, the scan record has passed the
// record register of every slot cell in the chain, and the done state commits the write and result
// the controller is back in idle in the cycle after the commit, so a new beat is taken only
// once the previous one has been committed; s_tready is high only while idle
// reset clears all slot valid bits, the iterator cursor and the output valid flag
// a stalled m_tready holds the commit, so the table is never updated ahead of the result
module keyed_table_with_oldest_store_eviction #(
	parameter int NUM_SLOTS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [2:0]   s_tuser,  // func
	input  logic [183:0] s_tdata,  // peer_addr, key_hi, key_lo, key_type
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [0:0]   m_tuser,  // res_found
	output logic [191:0] m_tdata   // res_addr, res_key_hi, res_key_lo, res_key_type, res_slot
);
	import kltc_pkg::*;

	localparam int CW = $clog2(NUM_SLOTS + 1);

	state_t            state_q;
	state_t            state_d;
	logic              s_fire;
	logic              commit;
	logic [2:0]        func_q;
	logic [ADDR_W-1:0] addr_q;
	logic [KEY_W-1:0]  key_hi_q;
	logic [KEY_W-1:0]  key_lo_q;
	logic [TYPE_W-1:0] key_type_q;
	logic [CW-1:0]     cursor_q;
	logic [CW-1:0]     cursor_d;
	scan_req_t         req;
	scan_rec_t         rec [NUM_SLOTS+1];
	logic              rec0_vld_q;
	scan_rec_t         fin;
	wr_cmd_t           wr;
	logic              res_found;
	logic [SLOT_W-1:0] res_slot;
	logic              m_tvalid_q;
	logic [0:0]        m_tuser_q;
	logic [191:0]      m_tdata_q;

	assign s_fire = s_tvalid && s_tready;

	// latch the request beat
	always_ff @(posedge clk) begin
		if (s_fire) begin
			func_q     <= s_tuser;
			addr_q     <= s_tdata[47:0];
			key_hi_q   <= s_tdata[111:48];
			key_lo_q   <= s_tdata[175:112];
			key_type_q <= s_tdata[183:176];
		end
	end

	assign req.func   = func_q;
	assign req.addr   = addr_q;
	assign req.cursor = (IDX_W+1)'(cursor_q);

	// empty record enters the chain the cycle after accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec0_vld_q <= 1'b0;
		end else begin
			rec0_vld_q <= s_fire;
		end
	end

	assign rec[0].vld          = rec0_vld_q;
	assign rec[0].match_hit    = 1'b0;
	assign rec[0].match_idx    = '0;
	assign rec[0].free_hit     = 1'b0;
	assign rec[0].free_idx     = '0;
	assign rec[0].min_seq      = '0;
	assign rec[0].min_idx      = '0;
	assign rec[0].max_seq      = '0;
	assign rec[0].hit          = 1'b0;
	assign rec[0].hit_idx      = '0;
	assign rec[0].hit_addr     = '0;
	assign rec[0].hit_key_hi   = '0;
	assign rec[0].hit_key_lo   = '0;
	assign rec[0].hit_key_type = '0;

	// slot cells
	for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
		kltc_cell #(.IDX(g)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.req    (req),
			.rec_in (rec[g]),
			.rec_out(rec[g+1]),
			.wr     (wr)
		);
	end

	assign fin = rec[NUM_SLOTS];

	// controller state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, write command, result and cursor update
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		commit    = 1'b0;
		wr        = '0;
		res_found = 1'b0;
		res_slot  = '0;
		cursor_d  = cursor_q;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (fin.vld)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				commit = !m_tvalid_q || m_tready;
				if (commit)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase

		wr.seq      = fin.max_seq + SEQ_W'(1);
		wr.addr     = addr_q;
		wr.key_hi   = key_hi_q;
		wr.key_lo   = key_lo_q;
		wr.key_type = key_type_q;
		case (func_q)
			FN_LOOKUP: begin
				res_found = fin.match_hit;
				if (fin.match_hit)
					res_slot = SLOT_W'(fin.match_idx);
			end
			FN_PUT: begin
				wr.put = commit;
				if (fin.match_hit)
					wr.idx = fin.match_idx;
				else if (fin.free_hit)
					wr.idx = fin.free_idx;
				else
					wr.idx = fin.min_idx;
				res_slot = SLOT_W'(wr.idx);
			end
			FN_DELETE: begin
				wr.del = commit && fin.match_hit;
				wr.idx = fin.match_idx;
				if (fin.match_hit)
					res_slot = SLOT_W'(fin.match_idx);
			end
			FN_CLEAR: begin
				wr.clr = commit;
			end
			FN_RESTART: begin
				if (commit)
					cursor_d = '0;
			end
			FN_NEXT: begin
				res_found = fin.hit;
				if (fin.hit)
					res_slot = SLOT_W'(fin.hit_idx);
				if (commit) begin
					if (fin.hit)
						cursor_d = CW'((IDX_W+1)'(fin.hit_idx) + (IDX_W+1)'(1));
					else
						cursor_d = CW'(NUM_SLOTS);
				end
			end
			default: ;
		endcase
	end

	// iterator cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else begin
			cursor_q <= cursor_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_tuser_q <= res_found;
			if (res_found)
				m_tdata_q <= {4'b0, res_slot, fin.hit_key_type, fin.hit_key_lo,
					fin.hit_key_hi, fin.hit_addr};
			else
				m_tdata_q <= {4'b0, res_slot, 184'b0};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

	// checks
	a_fin_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		fin.vld |-> state_q == ST_SCAN)
		else $error("scan record left the chain outside the scan phase");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= CW'(NUM_SLOTS))
		else $error("iterator cursor past the end of the table");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> !s_tready && !commit)
		else $error("new beat or commit right after accept");

endmodule
